// ===== rtl/core/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BEAMS_DEF    = 4096;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle constants (radians in Q16), CORDIC gain compensation in Q16, output limit
  localparam int TWO_PI_Q16  = 411775;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int GAIN_Q16    = 39797;
  localparam int OUT_LIMIT   = 65535;

  // Fixed field and datapath widths
  localparam int RANGE_W = 16;
  localparam int START_W = 20;
  localparam int STEP_W  = 18;
  localparam int CFG_W   = 20;
  localparam int CFG_A_W = 2;
  localparam int OUT_W   = 17;
  localparam int Z_W     = 32;
  localparam int XY_W    = 35;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 40;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_GATE_MIN    = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_GATE_MAX    = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_ANGLE_START = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_ANGLE_STEP  = 2'd3;

  // Residual angle handed to the rotator
  typedef struct packed {
    logic                  valid;
    logic                  flip;
    logic signed [Z_W-1:0] z;
  } ang_res_t;

  // Finished point from the rotator
  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } cor_res_t;

  // Arctangent of 2^-i in Q28
  function automatic logic [Z_W-1:0] atan_q28(input logic [4:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rsc_angle.sv =====
`default_nettype none
module rsc_angle #(
  parameter int IDX_W = $clog2(rsc_pkg::MAX_BEAMS_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rsc_pkg::START_W-1:0]  angle_start,
  input  wire logic [rsc_pkg::STEP_W-1:0]   angle_step,
  input  wire logic [IDX_W-1:0]             beam,
  output rsc_pkg::ang_res_t                 res
);
  import rsc_pkg::*;

  localparam int A_W   = IDX_W + 20;
  localparam int CNT_W = $clog2(A_W + 1);
  localparam int REM_W = 19;

  localparam logic signed [REM_W+1:0] S_TWO_PI  = (REM_W+2)'(TWO_PI_Q16);
  localparam logic signed [REM_W+1:0] S_PI      = (REM_W+2)'(PI_Q16);
  localparam logic signed [REM_W+1:0] S_HALF_PI = (REM_W+2)'(HALF_PI_Q16);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_MOD  = 3'b100
  } a_state_t;

  a_state_t                state;
  logic signed [A_W-1:0]   acc;
  logic signed [A_W-1:0]   mcand;
  logic [IDX_W-1:0]        mplier;
  logic [A_W-1:0]          mag;
  logic                    neg;
  logic [REM_W-1:0]        rem;
  logic [CNT_W-1:0]        cnt;
  logic                    res_valid;
  logic                    res_flip;
  logic signed [Z_W-1:0]   res_z;

  logic signed [A_W-1:0]   acc_next;
  logic [REM_W:0]          rem_t;
  logic [REM_W-1:0]        rem_next;
  logic signed [REM_W+1:0] a_red;
  logic signed [REM_W+1:0] a_fold;
  logic                    flip_next;

  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign rem_t    = {rem, mag[A_W-1]};
  assign rem_next = (rem_t >= (REM_W+1)'(TWO_PI_Q16)) ?
                    REM_W'(rem_t - (REM_W+1)'(TWO_PI_Q16)) : REM_W'(rem_t);

  // Bring the signed remainder into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    a_red = neg ? -$signed({2'b00, rem_next}) : $signed({2'b00, rem_next});
    if (a_red > S_PI) begin
      a_red = a_red - S_TWO_PI;
    end else if (a_red < -S_PI) begin
      a_red = a_red + S_TWO_PI;
    end
    flip_next = 1'b0;
    a_fold    = a_red;
    if (a_red > S_HALF_PI) begin
      a_fold    = a_red - S_PI;
      flip_next = 1'b1;
    end else if (a_red < -S_HALF_PI) begin
      a_fold    = a_red + S_PI;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= A_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        A_IDLE: begin
          if (start) begin
            acc    <= {{(A_W-START_W){angle_start[START_W-1]}}, angle_start};
            mcand  <= {{(A_W-STEP_W){angle_step[STEP_W-1]}}, angle_step};
            mplier <= beam;
            cnt    <= '0;
            state  <= A_MUL;
          end
        end
        A_MUL: begin
          // one index bit a cycle, multiplicand doubles
          acc    <= acc_next;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(IDX_W - 1)) begin
            neg   <= acc_next[A_W-1];
            mag   <= acc_next[A_W-1] ? A_W'(-acc_next) : A_W'(acc_next);
            rem   <= '0;
            cnt   <= '0;
            state <= A_MOD;
          end
        end
        A_MOD: begin
          // restoring remainder, one magnitude bit a cycle
          rem <= rem_next;
          mag <= mag << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(A_W - 1)) begin
            res_valid <= 1'b1;
            res_flip  <= flip_next;
            res_z     <= Z_W'(a_fold) <<< 12;
            state     <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign res.valid = res_valid;
  assign res.flip  = res_flip;
  assign res.z     = res_z;

endmodule
`default_nettype wire

// ===== rtl/core/rsc_cordic.sv =====
`default_nettype none
module rsc_cordic #(
  parameter int CORDIC_STEPS = rsc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rsc_pkg::RANGE_W-1:0]   range_mm,
  input  rsc_pkg::ang_res_t                  ang,
  output rsc_pkg::cor_res_t                  res
);
  import rsc_pkg::*;

  localparam int IT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_RUN   = 3'b010,
    C_ROUND = 3'b100
  } c_state_t;

  c_state_t               state;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic [IT_W-1:0]        it;
  logic                   flp;
  logic                   done;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  at;

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign at = $signed(atan_q28(5'(it)));

  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [XY_W-1:0] v, input logic neg_v);
    logic signed [XY_W:0] s;
    logic signed [XY_W:0] r;
    logic signed [OUT_W-1:0] o;
    s = neg_v ? -(XY_W+1)'(v) : (XY_W+1)'(v);
    r = (s + (XY_W+1)'(32768)) >>> 16;
    if (r > (XY_W+1)'(OUT_LIMIT)) begin
      o = OUT_W'(OUT_LIMIT);
    end else if (r < -(XY_W+1)'(OUT_LIMIT)) begin
      o = -OUT_W'(OUT_LIMIT);
    end else begin
      o = OUT_W'(r);
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            x     <= $signed({{(XY_W-32){1'b0}}, 32'(range_mm) * 32'(GAIN_Q16)});
            y     <= '0;
            z     <= ang.z;
            flp   <= ang.flip;
            it    <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z[Z_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          it <= it + 1'b1;
          if (it == IT_W'(CORDIC_STEPS - 1)) begin
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          x_out <= round_sat(x, flp);
          y_out <= round_sat(y, flp);
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.x    = x_out;
  assign res.y    = y_out;

endmodule
`default_nettype wire

// ===== rtl/core/range_scan_to_cartesian.sv =====
`default_nettype none
// Laser range scan to cartesian points. Each request carries one range sample
// (millimetres) and a scan-end flag on tlast; each produces exactly one result
// with x/y in millimetres, a keep flag on tuser (0: range outside the gate,
// x=y=0) and the scan-end copy on tlast. The beam index counts requests and
// restarts after scan end or on reaching MAX_BEAMS. The beam angle
// start + step*index is formed by a bit-serial shift-add multiplier (one index
// bit a cycle), reduced modulo two pi by a bit-serial restoring remainder (one
// bit a cycle), folded into [-pi/2, pi/2] and fed to a CORDIC rotator doing
// one iteration a cycle. One request is in work at a time: a kept sample
// passes the angle unit (IDX_W = clog2(MAX_BEAMS) index bits) and the CORDIC
// rotator, a dropped one goes straight to the output stage. The next
// request is taken from the cycle in which the result is offered; while an
// unclaimed result still blocks the output register, the finished one waits,
// and the next request with it. The result waits in an output register, so the
// next request is taken while it is still unclaimed.
module range_scan_to_cartesian #(
  parameter int MAX_BEAMS    = rsc_pkg::MAX_BEAMS_DEF,
  parameter int CORDIC_STEPS = rsc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [rsc_pkg::CFG_A_W-1:0]      cfg_index,
  input  wire logic [rsc_pkg::CFG_W-1:0]        cfg_data,
  // request stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [rsc_pkg::TDATA_IN_W-1:0]   s_tdata,  // [15:0] range_mm
  input  wire logic                             s_tlast,  // scan_end
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [rsc_pkg::TDATA_OUT_W-1:0]       m_tdata,  // [16:0] x_mm, [33:17] y_mm
  output logic                                  m_tuser,  // keep
  output logic                                  m_tlast   // scan_last
);
  import rsc_pkg::*;

  localparam int IDX_W = $clog2(MAX_BEAMS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ANGLE  = 4'b0010,
    S_CORDIC = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                  state;
  logic [RANGE_W-1:0]      gate_min_mm;
  logic [RANGE_W-1:0]      gate_max_mm;
  logic [START_W-1:0]      angle_start;
  logic [STEP_W-1:0]       angle_step;
  logic [IDX_W-1:0]        beam_index;
  logic [IDX_W-1:0]        beam_index_next;
  logic [IDX_W-1:0]        idx_q;
  logic [RANGE_W-1:0]      range_q;
  logic                    last_q;
  logic                    keep_q;
  logic                    ang_start;
  logic                    cor_start;
  logic signed [OUT_W-1:0] res_x;
  logic signed [OUT_W-1:0] res_y;
  logic                    in_acc;
  logic                    in_keep;
  logic                    out_free;
  ang_res_t                ang;
  cor_res_t                cor;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_keep  = (s_tdata[RANGE_W-1:0] >= gate_min_mm) &&
                    (s_tdata[RANGE_W-1:0] <= gate_max_mm);
  assign out_free = !m_tvalid || m_tready;

  // Restart after scan end, wrap at MAX_BEAMS
  always_comb begin
    if (s_tlast || beam_index == IDX_W'(MAX_BEAMS - 1)) begin
      beam_index_next = '0;
    end else begin
      beam_index_next = beam_index + 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_min_mm <= '0;
      gate_max_mm <= '1;
      angle_start <= '0;
      angle_step  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GATE_MIN:    gate_min_mm <= cfg_data[RANGE_W-1:0];
        REG_GATE_MAX:    gate_max_mm <= cfg_data[RANGE_W-1:0];
        REG_ANGLE_START: angle_start <= cfg_data[START_W-1:0];
        REG_ANGLE_STEP:  angle_step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Request sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      beam_index <= '0;
      ang_start  <= 1'b0;
      cor_start  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      ang_start <= 1'b0;
      cor_start <= 1'b0;
      // load a finished result, or drop the offered one once taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            range_q    <= s_tdata[RANGE_W-1:0];
            last_q     <= s_tlast;
            keep_q     <= in_keep;
            idx_q      <= beam_index;
            beam_index <= beam_index_next;
            if (in_keep) begin
              ang_start <= 1'b1;
              state     <= S_ANGLE;
            end else begin
              // drop: result is a zero point
              res_x <= '0;
              res_y <= '0;
              state <= S_DONE;
            end
          end
        end
        S_ANGLE: begin
          if (ang.valid) begin
            cor_start <= 1'b1;
            state     <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cor.done) begin
            res_x <= cor.x;
            res_y <= cor.y;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            m_tdata  <= {(TDATA_OUT_W-2*OUT_W)'(0), res_y, res_x};
            m_tuser  <= keep_q;
            m_tlast  <= last_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rsc_angle #(
    .IDX_W(IDX_W)
  ) u_angle (
    .clk        (clk),
    .rst        (rst),
    .start      (ang_start),
    .angle_start(angle_start),
    .angle_step (angle_step),
    .beam       (idx_q),
    .res        (ang)
  );

  rsc_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .range_mm(range_q),
    .ang     (ang),
    .res     (cor)
  );

endmodule
`default_nettype wire

// ===== rtl/core/rsc_checker.sv =====
`default_nettype none
module rsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  // a dropped sample carries a zero point
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[33:0] == 34'd0))
    else $error("dropped sample with non-zero point");

  // one request in work: no accept in the cycle after an accept
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while previous one in work");

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // an offered result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn before taken");

endmodule

bind range_scan_to_cartesian rsc_checker u_rsc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire
